// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file dfsdag_checker.sv.
// Depends on nothing; each macro takes a label, clock, active low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- design/dfsdag_pkg.sv -----
// Package of the graph search unit: item and result words, kind and status codes.
// Depends on nothing.
package dfsdag_pkg;

	localparam logic [2:0] K_ADD  = 3'd0;
	localparam logic [2:0] K_RUN  = 3'd1;
	localparam logic [2:0] K_VERT = 3'd2;
	localparam logic [2:0] K_TOPO = 3'd3;
	localparam logic [2:0] K_BACK = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_VERT = 2'd2;
	localparam logic [1:0] ST_IDX  = 2'd3;

	typedef struct packed {
		logic [2:0] kind;
		logic [6:0] from_vertex;
		logic [6:0] to_vertex;
		logic [7:0] position;
	} item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              is_dag;
		logic [8:0]        count;
		logic [6:0]        first_vertex;
		logic [6:0]        second_vertex;
		logic signed [7:0] first_entry;
		logic signed [7:0] first_exit;
		logic signed [7:0] second_entry;
		logic signed [7:0] second_exit;
		logic signed [7:0] predecessor;
	} result_t;

endpackage

// ----- design/dfsdag_ram.sv -----
// Generic single write port, single read port RAM with a registered read.
// Depends on nothing.
module dfsdag_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/depth_first_search_dag_check_unit.sv -----
// Top level of the graph search unit: sequencer around the edge, vertex, stack and result RAMs.
// Depends on dfsdag_pkg and dfsdag_ram.
//
// A word is taken when start is high and busy is low; its result is shown on result for one
// cycle with done high and cannot be held off. Errors answer in the next cycle. Add edge
// passes S_ADD_RD and, for a non-empty list, S_ADD_LK; reads pass S_QF, S_QT then S_QF, or
// S_QB, S_QBS and S_QBT. A run first clears the vertex entry and exit times and then walks
// the graph one RAM access at a time. After reset, busy stays high while the list heads and
// vertex times are cleared.
module depth_first_search_dag_check_unit #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES    = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  dfsdag_pkg::item_t   item,
	output logic                done,
	output dfsdag_pkg::result_t result,
	input  logic                cfg_we,
	input  logic [6:0]          cfg_data
);
	import dfsdag_pkg::*;

	localparam int VW  = $clog2(MAX_VERTICES);
	localparam int VNW = $clog2(MAX_VERTICES + 2);
	localparam int EW  = $clog2(MAX_EDGES);
	localparam int LW  = $clog2(MAX_EDGES + 1);
	localparam int SPW = $clog2(MAX_VERTICES + 1);
	localparam int TW  = $clog2(2 * MAX_VERTICES);
	localparam logic [LW-1:0] LNIL = LW'(MAX_EDGES);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_RCLR   = 5'd1;
	localparam logic [4:0] S_ADD_RD = 5'd2;
	localparam logic [4:0] S_ADD_LK = 5'd3;
	localparam logic [4:0] S_CLR    = 5'd4;
	localparam logic [4:0] S_ENTER  = 5'd5;
	localparam logic [4:0] S_PUSH   = 5'd6;
	localparam logic [4:0] S_LOOP   = 5'd7;
	localparam logic [4:0] S_POP    = 5'd8;
	localparam logic [4:0] S_EDGE   = 5'd9;
	localparam logic [4:0] S_ENTCHK = 5'd10;
	localparam logic [4:0] S_NEXT   = 5'd11;
	localparam logic [4:0] S_OCHK   = 5'd12;
	localparam logic [4:0] S_BSH    = 5'd13;
	localparam logic [4:0] S_BSHW   = 5'd14;
	localparam logic [4:0] S_BSE    = 5'd15;
	localparam logic [4:0] S_BST    = 5'd16;
	localparam logic [4:0] S_BSX    = 5'd17;
	localparam logic [4:0] S_QF     = 5'd18;
	localparam logic [4:0] S_QT     = 5'd19;
	localparam logic [4:0] S_QB     = 5'd20;
	localparam logic [4:0] S_QBS    = 5'd21;
	localparam logic [4:0] S_QBT    = 5'd22;

	typedef struct packed {
		logic [LW-1:0] head;
		logic [LW-1:0] tail;
	} vl_t;

	typedef struct packed {
		logic           ev;
		logic [TW-1:0]  et;
		logic           pv;
		logic [VNW-1:0] p;
	} ent_t;

	typedef struct packed {
		logic          xv;
		logic [TW-1:0] xt;
	} ext_t;

	typedef struct packed {
		logic [VNW-1:0] v;
		logic [LW-1:0]  e;
	} stk_t;

	typedef struct packed {
		logic [VNW-1:0] s;
		logic [VNW-1:0] t;
	} bk_t;

	function automatic logic [VW-1:0] va(input logic [31:0] v);
		logic [31:0] d;
		d = v - 32'd1;
		return d[VW-1:0];
	endfunction

	function automatic logic okv(input logic [31:0] v, input logic [VNW-1:0] n);
		return (v != 32'd0) && (v <= 32'(n));
	endfunction

	function automatic logic [7:0] t8(input logic vld, input logic [TW-1:0] t);
		logic [31:0] w;
		w = 32'(t);
		return vld ? w[7:0] : 8'hFF;
	endfunction

	function automatic logic [7:0] p8(input logic vld, input logic [VNW-1:0] p);
		logic [31:0] w;
		w = 32'(p);
		return vld ? w[7:0] : 8'hFF;
	endfunction

	function automatic logic [6:0] v7(input logic [VNW-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[6:0];
	endfunction

	logic [4:0]     state_q;
	item_t          item_q;
	result_t        res_q;
	logic           done_q;
	logic [VNW-1:0] n_q;
	logic [LW-1:0]  etot_q;
	logic [LW-1:0]  bcnt_q;
	logic [SPW-1:0] fin_q;
	logic [SPW-1:0] sp_q;
	logic [TW-1:0]  time_q;
	logic           dag_q;
	logic           first_q;
	logic [VW-1:0]  cidx_q;
	logic [VNW-1:0] cv_q;
	logic [LW-1:0]  ce_q;
	logic [VNW-1:0] u_q;
	logic [VNW-1:0] p_q;
	logic           pv_q;
	logic [VNW-1:0] i_q;
	logic [LW-1:0]  tail_q;
	logic [TW-1:0]  srcx_q;
	logic [VNW-1:0] sec_q;
	logic [VNW-1:0] nxt_i;

	logic           vl_we, et_we, en_we, ent_we, ext_we, stk_we, topo_we, bk_we;
	logic [VW-1:0]  vl_wa, vl_ra, ent_wa, ent_ra, ext_wa, ext_ra;
	logic [VW-1:0]  stk_wa, stk_ra, topo_wa, topo_ra;
	logic [EW-1:0]  et_wa, en_wa, e_ra, bk_wa, bk_ra;
	vl_t            vl_wd, vl_rd;
	logic [VNW-1:0] et_wd, et_rd, topo_wd, topo_rd;
	logic [LW-1:0]  en_wd, en_rd;
	ent_t           ent_wd, ent_rd;
	ext_t           ext_wd, ext_rd;
	stk_t           stk_wd, stk_rd;
	bk_t            bk_wd, bk_rd;

	logic accept;

	assign accept = start && !busy;
	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = res_q;
	assign nxt_i  = first_q ? VNW'(1) : i_q + VNW'(1);
	assign e_ra   = ce_q[EW-1:0];

	dfsdag_ram #(.WIDTH($bits(vl_t)), .DEPTH(MAX_VERTICES)) u_vl (
		.clk(clk), .we(vl_we), .waddr(vl_wa), .wdata(vl_wd), .raddr(vl_ra), .rdata(vl_rd));
	dfsdag_ram #(.WIDTH(VNW), .DEPTH(MAX_EDGES)) u_et (
		.clk(clk), .we(et_we), .waddr(et_wa), .wdata(et_wd), .raddr(e_ra), .rdata(et_rd));
	dfsdag_ram #(.WIDTH(LW), .DEPTH(MAX_EDGES)) u_en (
		.clk(clk), .we(en_we), .waddr(en_wa), .wdata(en_wd), .raddr(e_ra), .rdata(en_rd));
	dfsdag_ram #(.WIDTH($bits(ent_t)), .DEPTH(MAX_VERTICES)) u_ent (
		.clk(clk), .we(ent_we), .waddr(ent_wa), .wdata(ent_wd), .raddr(ent_ra),
		.rdata(ent_rd));
	dfsdag_ram #(.WIDTH($bits(ext_t)), .DEPTH(MAX_VERTICES)) u_ext (
		.clk(clk), .we(ext_we), .waddr(ext_wa), .wdata(ext_wd), .raddr(ext_ra),
		.rdata(ext_rd));
	dfsdag_ram #(.WIDTH($bits(stk_t)), .DEPTH(MAX_VERTICES)) u_stk (
		.clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra),
		.rdata(stk_rd));
	dfsdag_ram #(.WIDTH(VNW), .DEPTH(MAX_VERTICES)) u_topo (
		.clk(clk), .we(topo_we), .waddr(topo_wa), .wdata(topo_wd), .raddr(topo_ra),
		.rdata(topo_rd));
	dfsdag_ram #(.WIDTH($bits(bk_t)), .DEPTH(MAX_EDGES)) u_bk (
		.clk(clk), .we(bk_we), .waddr(bk_wa), .wdata(bk_wd), .raddr(bk_ra), .rdata(bk_rd));

	always_comb begin
		logic [31:0] tpos;
		logic [31:0] ppos;
		logic [31:0] spm;
		tpos    = 32'(fin_q) - 32'd1 - 32'(item.position);
		ppos    = 32'(item.position);
		spm     = 32'(sp_q) - 32'd2;
		vl_we   = 1'b0;
		vl_wa   = '0;
		vl_wd   = '0;
		vl_ra   = '0;
		et_we   = 1'b0;
		et_wa   = '0;
		et_wd   = '0;
		en_we   = 1'b0;
		en_wa   = '0;
		en_wd   = '0;
		ent_we  = 1'b0;
		ent_wa  = '0;
		ent_wd  = '0;
		ent_ra  = '0;
		ext_we  = 1'b0;
		ext_wa  = '0;
		ext_wd  = '0;
		ext_ra  = '0;
		stk_we  = 1'b0;
		stk_wa  = '0;
		stk_wd  = '0;
		stk_ra  = '0;
		topo_we = 1'b0;
		topo_wa = '0;
		topo_wd = '0;
		topo_ra = '0;
		bk_we   = 1'b0;
		bk_wa   = '0;
		bk_wd   = '0;
		bk_ra   = '0;
		unique case (state_q)
			S_IDLE: begin
				vl_ra   = va(32'(item.from_vertex));
				ent_ra  = va(32'(item.from_vertex));
				ext_ra  = va(32'(item.from_vertex));
				topo_ra = tpos[VW-1:0];
				bk_ra   = ppos[EW-1:0];
			end
			S_RCLR: begin
				vl_we  = 1'b1;
				vl_wa  = cidx_q;
				vl_wd  = '{head: LNIL, tail: LNIL};
				ent_we = 1'b1;
				ent_wa = cidx_q;
				ext_we = 1'b1;
				ext_wa = cidx_q;
			end
			S_CLR: begin
				ent_we = 1'b1;
				ent_wa = cidx_q;
				ext_we = 1'b1;
				ext_wa = cidx_q;
			end
			S_ADD_RD: begin
				vl_we = 1'b1;
				vl_wa = va(32'(item_q.from_vertex));
				vl_wd = '{head: (vl_rd.tail == LNIL) ? etot_q : vl_rd.head, tail: etot_q};
				et_we = 1'b1;
				et_wa = etot_q[EW-1:0];
				et_wd = VNW'(item_q.to_vertex);
				en_we = 1'b1;
				en_wa = etot_q[EW-1:0];
				en_wd = LNIL;
			end
			S_ADD_LK: begin
				en_we = 1'b1;
				en_wa = tail_q[EW-1:0];
				en_wd = etot_q;
			end
			S_ENTER: begin
				ent_we = 1'b1;
				ent_wa = va(32'(u_q));
				ent_wd = '{ev: 1'b1, et: time_q, pv: pv_q, p: p_q};
				vl_ra  = va(32'(u_q));
			end
			S_PUSH: begin
				stk_we = sp_q != '0;
				stk_wa = va(32'(sp_q));
				stk_wd = '{v: cv_q, e: ce_q};
			end
			S_LOOP: begin
				if (ce_q == LNIL) begin
					ext_we  = 1'b1;
					ext_wa  = va(32'(cv_q));
					ext_wd  = '{xv: 1'b1, xt: time_q};
					topo_we = 32'(fin_q) < MAX_VERTICES;
					topo_wa = fin_q[VW-1:0];
					topo_wd = cv_q;
					stk_ra  = spm[VW-1:0];
				end
			end
			S_EDGE: begin
				ent_ra = va(32'(et_rd));
			end
			S_NEXT: begin
				ent_ra = va(32'(nxt_i));
			end
			S_BSH: begin
				vl_ra  = va(32'(i_q));
				ext_ra = va(32'(i_q));
			end
			S_BST: begin
				ext_ra = va(32'(et_rd));
			end
			S_BSX: begin
				bk_we = (srcx_q < ext_rd.xt) && (32'(bcnt_q) < MAX_EDGES);
				bk_wa = bcnt_q[EW-1:0];
				bk_wd = '{s: i_q, t: u_q};
			end
			S_QT: begin
				ent_ra = va(32'(topo_rd));
				ext_ra = va(32'(topo_rd));
			end
			S_QB: begin
				ent_ra = va(32'(bk_rd.s));
				ext_ra = va(32'(bk_rd.s));
			end
			S_QBS: begin
				ent_ra = va(32'(sec_q));
				ext_ra = va(32'(sec_q));
			end
			S_POP, S_ENTCHK, S_OCHK, S_BSHW, S_BSE, S_QF, S_QBT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RCLR;
			item_q  <= '0;
			res_q   <= '0;
			done_q  <= 1'b0;
			n_q     <= VNW'(1);
			etot_q  <= '0;
			bcnt_q  <= '0;
			fin_q   <= '0;
			sp_q    <= '0;
			time_q  <= '0;
			dag_q   <= 1'b0;
			first_q <= 1'b0;
			cidx_q  <= '0;
			cv_q    <= '0;
			ce_q    <= '0;
			u_q     <= '0;
			p_q     <= '0;
			pv_q    <= 1'b0;
			i_q     <= '0;
			tail_q  <= '0;
			srcx_q  <= '0;
			sec_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				n_q <= (32'(cfg_data) > MAX_VERTICES) ? VNW'(MAX_VERTICES) : VNW'(cfg_data);
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						item_q <= item;
						res_q  <= '{status: ST_OK, is_dag: dag_q, count: 9'(bcnt_q),
							first_vertex: 7'd0, second_vertex: 7'd0, first_entry: 8'hFF,
							first_exit: 8'hFF, second_entry: 8'hFF, second_exit: 8'hFF,
							predecessor: 8'hFF};
						unique case (item.kind)
							K_ADD: begin
								res_q.count <= 9'(etot_q);
								if (!okv(32'(item.from_vertex), n_q) ||
									!okv(32'(item.to_vertex), n_q)) begin
									res_q.status <= ST_VERT;
									done_q       <= 1'b1;
								end else if (32'(etot_q) == MAX_EDGES) begin
									res_q.status <= ST_FULL;
									done_q       <= 1'b1;
								end else begin
									state_q <= S_ADD_RD;
								end
							end
							K_RUN: begin
								if (!okv(32'(item.from_vertex), n_q)) begin
									res_q.status <= ST_VERT;
									done_q       <= 1'b1;
								end else begin
									cidx_q  <= '0;
									time_q  <= '0;
									fin_q   <= '0;
									bcnt_q  <= '0;
									sp_q    <= '0;
									first_q <= 1'b1;
									state_q <= S_CLR;
								end
							end
							K_VERT: begin
								if (!okv(32'(item.from_vertex), n_q)) begin
									res_q.status <= ST_VERT;
									done_q       <= 1'b1;
								end else begin
									res_q.first_vertex <= item.from_vertex;
									state_q            <= S_QF;
								end
							end
							K_TOPO: begin
								if (32'(item.position) >= 32'(fin_q)) begin
									res_q.status <= ST_IDX;
									done_q       <= 1'b1;
								end else begin
									state_q <= S_QT;
								end
							end
							K_BACK: begin
								if (32'(item.position) >= 32'(bcnt_q)) begin
									res_q.status <= ST_IDX;
									done_q       <= 1'b1;
								end else begin
									state_q <= S_QB;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_RCLR: begin
					cidx_q <= cidx_q + VW'(1);
					if (cidx_q == VW'(MAX_VERTICES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_ADD_RD: begin
					tail_q <= vl_rd.tail;
					if (vl_rd.tail == LNIL) begin
						etot_q      <= etot_q + LW'(1);
						res_q.count <= 9'(etot_q + LW'(1));
						done_q      <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_ADD_LK;
					end
				end
				S_ADD_LK: begin
					etot_q      <= etot_q + LW'(1);
					res_q.count <= 9'(etot_q + LW'(1));
					done_q      <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_CLR: begin
					cidx_q <= cidx_q + VW'(1);
					if (cidx_q == VW'(MAX_VERTICES - 1)) begin
						u_q     <= VNW'(item_q.from_vertex);
						pv_q    <= 1'b0;
						state_q <= S_ENTER;
					end
				end
				S_ENTER: begin
					time_q  <= time_q + TW'(1);
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					cv_q    <= u_q;
					ce_q    <= vl_rd.head;
					sp_q    <= sp_q + SPW'(1);
					state_q <= S_LOOP;
				end
				S_LOOP: begin
					if (ce_q == LNIL) begin
						time_q <= time_q + TW'(1);
						if (32'(fin_q) < MAX_VERTICES) begin
							fin_q <= fin_q + SPW'(1);
						end
						sp_q <= sp_q - SPW'(1);
						state_q <= (sp_q > SPW'(1)) ? S_POP : S_NEXT;
					end else begin
						state_q <= S_EDGE;
					end
				end
				S_POP: begin
					cv_q    <= stk_rd.v;
					ce_q    <= stk_rd.e;
					state_q <= S_LOOP;
				end
				S_EDGE: begin
					ce_q    <= en_rd;
					u_q     <= et_rd;
					state_q <= okv(32'(et_rd), n_q) ? S_ENTCHK : S_LOOP;
				end
				S_ENTCHK: begin
					if (!ent_rd.ev && (32'(sp_q) < MAX_VERTICES)) begin
						pv_q    <= 1'b1;
						p_q     <= cv_q;
						state_q <= S_ENTER;
					end else begin
						state_q <= S_LOOP;
					end
				end
				S_NEXT: begin
					first_q <= 1'b0;
					if (nxt_i > n_q) begin
						i_q     <= VNW'(1);
						state_q <= S_BSH;
					end else begin
						i_q     <= nxt_i;
						state_q <= S_OCHK;
					end
				end
				S_OCHK: begin
					if (!ent_rd.ev) begin
						u_q     <= i_q;
						pv_q    <= 1'b0;
						state_q <= S_ENTER;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_BSH: begin
					state_q <= S_BSHW;
				end
				S_BSHW: begin
					ce_q    <= vl_rd.head;
					srcx_q  <= ext_rd.xt;
					state_q <= S_BSE;
				end
				S_BSE: begin
					if (ce_q == LNIL) begin
						if (i_q == n_q) begin
							dag_q        <= bcnt_q == '0;
							res_q.is_dag <= bcnt_q == '0;
							res_q.count  <= 9'(bcnt_q);
							done_q       <= 1'b1;
							state_q      <= S_IDLE;
						end else begin
							i_q     <= i_q + VNW'(1);
							state_q <= S_BSH;
						end
					end else begin
						state_q <= S_BST;
					end
				end
				S_BST: begin
					ce_q    <= en_rd;
					u_q     <= et_rd;
					state_q <= okv(32'(et_rd), n_q) ? S_BSX : S_BSE;
				end
				S_BSX: begin
					if ((srcx_q < ext_rd.xt) && (32'(bcnt_q) < MAX_EDGES)) begin
						bcnt_q <= bcnt_q + LW'(1);
					end
					state_q <= S_BSE;
				end
				S_QF: begin
					res_q.first_entry <= t8(ent_rd.ev, ent_rd.et);
					res_q.first_exit  <= t8(ext_rd.xv, ext_rd.xt);
					res_q.predecessor <= p8(ent_rd.pv, ent_rd.p);
					done_q            <= 1'b1;
					state_q           <= S_IDLE;
				end
				S_QT: begin
					res_q.first_vertex <= v7(topo_rd);
					state_q            <= S_QF;
				end
				S_QB: begin
					res_q.first_vertex  <= v7(bk_rd.s);
					res_q.second_vertex <= v7(bk_rd.t);
					sec_q               <= bk_rd.t;
					state_q             <= S_QBS;
				end
				S_QBS: begin
					res_q.first_entry <= t8(ent_rd.ev, ent_rd.et);
					res_q.first_exit  <= t8(ext_rd.xv, ext_rd.xt);
					res_q.predecessor <= p8(ent_rd.pv, ent_rd.p);
					state_q           <= S_QBT;
				end
				S_QBT: begin
					res_q.second_entry <= t8(ent_rd.ev, ent_rd.et);
					res_q.second_exit  <= t8(ext_rd.xv, ext_rd.xt);
					done_q             <= 1'b1;
					state_q            <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- design/dfsdag_checker.sv -----
// Port-level checks of the graph search unit, bound to its top level.
// Depends on dfsdag_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dfsdag_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input dfsdag_pkg::result_t result
);
	import dfsdag_pkg::*;

	logic err_shown;
	logic err_blank;
	logic two_shown;

	assign err_shown = done && (result.status != ST_OK);
	assign err_blank = (result.first_vertex == 7'd0) && (result.first_entry == 8'hFF);
	assign two_shown = done && (result.second_vertex != 7'd0);

	`ASSERT_NEXT(a_accept_answered, clk, arst_n, start && !busy, done || busy)
	`ASSERT_IMPLY(a_done_follows_work, clk, arst_n, done, $past(busy) || $past(start))
	`ASSERT_IMPLY(a_error_empty, clk, arst_n, err_shown, err_blank)
	`ASSERT_IMPLY(a_second_needs_first, clk, arst_n, two_shown, result.first_vertex != 7'd0)

endmodule

bind depth_first_search_dag_check_unit dfsdag_checker u_dfsdag_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.result(result)
);
